// ----- hdl/assert_macros.svh -----
// assertion macros for the block checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CHK_RUN(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge
`define CHK_ALL(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hdl/bbps_pkg.sv -----
// shared types, constants and functions of the block parity hiding core
package bbps_pkg;

    localparam int unsigned CELLS = 9;
    localparam logic [8:0] KEY_RESET = 9'd186;

    typedef enum logic [1:0] {
        MODE_EMBED   = 2'd0,
        MODE_EXTRACT = 2'd1,
        MODE_CLEAR   = 2'd2
    } mode_t;

    typedef struct packed {
        logic masked;
        logic elig_zero;
        logic elig_one;
        logic elig_any;
    } lane_t;

    typedef struct packed {
        logic       used;
        logic [8:0] out_block;
        logic       data_bit;
        logic       s_par;
    } merge_t;

    typedef struct packed {
        logic       block_used;
        logic [8:0] out_block;
        logic       data_bit;
        logic       byte_ready;
        logic [7:0] byte_value;
        logic       byte_ok;
        logic       halted;
    } res_t;

    function automatic logic printable(input logic [7:0] c);
        logic hit;
        hit = (c == 8'd32) || (c == 8'd33) || (c == 8'd34) || (c == 8'd39) ||
              (c == 8'd40) || (c == 8'd41) || (c == 8'd44) || (c == 8'd46) ||
              (c == 8'd63);
        hit = hit || ((c >= 8'd48) && (c <= 8'd57));
        hit = hit || ((c >= 8'd65) && (c <= 8'd90));
        hit = hit || ((c >= 8'd97) && (c <= 8'd122));
        return hit;
    endfunction

endpackage

// ----- hdl/bbps_lane.sv -----
// one cell lane: masked pixel and flip eligibility per class
module bbps_lane (
    input  logic             key_bit,
    input  logic             pixel_bit,
    output bbps_pkg::lane_t  lane
);

    always_comb begin
        lane.masked    = key_bit & pixel_bit;
        lane.elig_zero = key_bit & ~pixel_bit;
        lane.elig_one  = key_bit & pixel_bit;
        lane.elig_any  = key_bit;
    end

endmodule

// ----- hdl/bbps_merge.sv -----
// merge of the lane results: counts, usability, rotated cell choice, parity
module bbps_merge (
    input  bbps_pkg::lane_t [8:0] lanes,
    input  logic [8:0]            block_bits,
    input  logic                  embed_en,
    input  logic                  message_bit,
    input  logic [3:0]            pick,
    output bbps_pkg::merge_t      res
);

    logic [3:0]  s_cnt;
    logic [3:0]  k_cnt;
    logic [8:0]  key_vec;
    logic [8:0]  elig;
    logic [3:0]  pick_m;
    logic [17:0] elig2;
    logic [17:0] rot2;
    logic [8:0]  rot;
    logic [8:0]  first;
    logic [17:0] unrot2;
    logic [8:0]  flip;
    logic        used;
    logic        s_one;
    logic        s_top;
    logic [8:0]  ob;

    always_comb begin
        s_cnt   = 4'd0;
        k_cnt   = 4'd0;
        key_vec = '0;
        for (int i = 0; i < 9; i++) begin
            s_cnt      = s_cnt + {3'd0, lanes[i].masked};
            k_cnt      = k_cnt + {3'd0, lanes[i].elig_any};
            key_vec[i] = lanes[i].elig_any;
        end
    end

    assign used  = (s_cnt != 4'd0) && (s_cnt < k_cnt);
    assign s_one = (s_cnt == 4'd1);
    assign s_top = ((s_cnt + 4'd1) == k_cnt);

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            if (s_one) begin
                elig[i] = lanes[i].elig_zero;
            end else if (s_top) begin
                elig[i] = lanes[i].elig_one;
            end else begin
                elig[i] = lanes[i].elig_any;
            end
        end
    end

    // first eligible cell at or after pick, wrapping
    assign pick_m = (pick >= 4'd9) ? (pick - 4'd9) : pick;
    assign elig2  = {elig, elig};
    assign rot2   = elig2 >> pick_m;
    assign rot    = rot2[8:0];
    assign first  = rot & (~rot + 9'd1);
    assign unrot2 = {first, first} << pick_m;
    assign flip   = unrot2[17:9];

    assign ob = (embed_en && used && (s_cnt[0] != message_bit)) ? (block_bits ^ flip)
                                                                : block_bits;

    always_comb begin
        res.used      = used;
        res.out_block = ob;
        res.s_par     = s_cnt[0];
        res.data_bit  = embed_en ? ^(ob & key_vec) : s_cnt[0];
    end

endmodule

// ----- hdl/binary_block_parity_stego_core.sv -----
// Results are registered in the output register, or in the skid word on a stall.
// One word per cycle while s_ready is high; nine cell lanes and merge are combinational.
// A two-entry result buffer (output register plus skid) keeps s_ready high while
// one result waits. Synchronous active-low reset sets the key to 186 and clears
// the byte shifter, bit position, halt flag and result buffer.
module binary_block_parity_stego_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_key_mask,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [8:0] s_block_bits,
    input  logic       s_message_bit,
    input  logic [3:0] s_pick,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_block_used,
    output logic [8:0] m_out_block,
    output logic       m_data_bit,
    output logic       m_byte_ready,
    output logic [7:0] m_byte_value,
    output logic       m_byte_ok,
    output logic       m_halted
);

    logic [8:0]             key_reg;
    logic [7:0]             shift_reg;
    logic [7:0]             shift_next;
    logic [2:0]             pos_reg;
    logic [2:0]             pos_next;
    logic                   stop_reg;
    logic                   stop_next;
    bbps_pkg::lane_t [8:0]  lanes;
    bbps_pkg::merge_t       mrg;
    bbps_pkg::res_t         res_next;
    bbps_pkg::res_t         main_reg;
    bbps_pkg::res_t         skid_reg;
    logic                   main_valid_reg;
    logic                   skid_valid_reg;
    logic                   accept;
    logic [7:0]             shifted;

    assign cfg_ready = 1'b1;
    assign s_ready   = ~skid_valid_reg;
    assign accept    = s_valid & s_ready;

    for (genvar g = 0; g < bbps_pkg::CELLS; g++) begin : g_lane
        bbps_lane u_lane (
            .key_bit   (key_reg[g]),
            .pixel_bit (s_block_bits[g]),
            .lane      (lanes[g])
        );
    end

    bbps_merge u_merge (
        .lanes       (lanes),
        .block_bits  (s_block_bits),
        .embed_en    (s_mode == bbps_pkg::MODE_EMBED),
        .message_bit (s_message_bit),
        .pick        (s_pick),
        .res         (mrg)
    );

    assign shifted = {shift_reg[6:0], mrg.s_par};

    always_comb begin
        shift_next          = shift_reg;
        pos_next            = pos_reg;
        stop_next           = stop_reg;
        res_next.block_used = 1'b0;
        res_next.out_block  = s_block_bits;
        res_next.data_bit   = 1'b0;
        res_next.byte_ready = 1'b0;
        res_next.byte_value = 8'd0;
        res_next.byte_ok    = 1'b0;
        unique case (s_mode)
            bbps_pkg::MODE_CLEAR: begin
                shift_next = 8'd0;
                pos_next   = 3'd0;
                stop_next  = 1'b0;
            end
            bbps_pkg::MODE_EMBED: begin
                res_next.block_used = mrg.used;
                res_next.out_block  = mrg.out_block;
                res_next.data_bit   = mrg.used & mrg.data_bit;
            end
            bbps_pkg::MODE_EXTRACT: begin
                res_next.block_used = mrg.used;
                res_next.data_bit   = mrg.used & mrg.s_par;
                if (mrg.used && !stop_reg) begin
                    if (pos_reg == 3'd7) begin
                        res_next.byte_ready = 1'b1;
                        res_next.byte_value = shifted;
                        res_next.byte_ok    = bbps_pkg::printable(shifted);
                        stop_next           = ~bbps_pkg::printable(shifted);
                        shift_next          = 8'd0;
                        pos_next            = 3'd0;
                    end else begin
                        shift_next = shifted;
                        pos_next   = pos_reg + 3'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        res_next.halted = stop_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= bbps_pkg::KEY_RESET;
            shift_reg <= 8'd0;
            pos_reg   <= 3'd0;
            stop_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                key_reg <= cfg_key_mask;
            end
            if (accept) begin
                shift_reg <= shift_next;
                pos_reg   <= pos_next;
                stop_reg  <= stop_next;
            end
        end
    end

    // output register with skid word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || m_ready) begin
            main_reg <= skid_valid_reg ? skid_reg : res_next;
        end else if (accept) begin
            skid_reg <= res_next;
        end
    end

    assign m_valid      = main_valid_reg;
    assign m_block_used = main_reg.block_used;
    assign m_out_block  = main_reg.out_block;
    assign m_data_bit   = main_reg.data_bit;
    assign m_byte_ready = main_reg.byte_ready;
    assign m_byte_value = main_reg.byte_value;
    assign m_byte_ok    = main_reg.byte_ok;
    assign m_halted     = main_reg.halted;

endmodule

// ----- hdl/bbps_checker.sv -----
// port-level checks of the core, bound to the top level
`include "assert_macros.svh"

module bbps_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_block_used,
    input logic [8:0] m_out_block,
    input logic       m_data_bit,
    input logic       m_byte_ready,
    input logic       m_byte_ok,
    input logic       m_halted
);

    `CHK_ALL(a_stall_has_word, (!s_ready |-> m_valid), "input stalled with no word pending")
    `CHK_RUN(a_no_phantom, ($rose(m_valid) |-> $past(s_valid && s_ready)), "result without input word")
    `CHK_RUN(a_ok_is_byte, ((m_valid && m_byte_ok) |-> (m_byte_ready && !m_halted)), "byte_ok without clean byte")
    `CHK_RUN(a_unused_quiet, ((m_valid && !m_block_used) |-> (!m_data_bit && !m_byte_ready)), "unused block reports data")
    `CHK_RUN(a_hold, ((m_valid && !m_ready) |=> (m_valid && $stable(m_out_block))), "stalled word changed")

endmodule

bind binary_block_parity_stego_core bbps_checker u_bbps_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_block_used (m_block_used),
    .m_out_block  (m_out_block),
    .m_data_bit   (m_data_bit),
    .m_byte_ready (m_byte_ready),
    .m_byte_ok    (m_byte_ok),
    .m_halted     (m_halted)
);
